FILE: hdl/bdeq_pkg.sv
package bdeq_pkg;

    localparam int CAPACITY = 64;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADD_W    = PTR_W + 1;
    localparam int WORD_W   = 32;
    localparam int LIMIT_W  = 7;
    localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    typedef enum logic [1:0] {
        KIND_PUSH_TOP    = 2'd0,
        KIND_PUSH_BOTTOM = 2'd1,
        KIND_POP_TOP     = 2'd2,
        KIND_POP_BOTTOM  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

FILE: hdl/bdeq_ram.sv
module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bdeq_ctrl.sv
module bdeq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_strobe,
    output bdeq_pkg::t_cmd o_cmd
);

    import bdeq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_strobe <= 1'b0;
                    if (i_start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state  <= S_DONE;
                    r_strobe <= 1'b1;
                end
                S_DONE: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b0;
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy      = r_busy;
    assign o_strobe    = r_strobe;
    assign o_cmd.load  = i_start && !r_busy;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

FILE: hdl/bdeq_dp.sv
module bdeq_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bdeq_pkg::t_cmd                  i_cmd,
    input  logic [1:0]                      i_kind,
    input  logic signed [31:0]              i_push_value,
    input  logic                            i_cfg_we,
    input  logic [bdeq_pkg::LIMIT_W-1:0]    i_cfg_data,
    output logic signed [31:0]              o_pop_value,
    output logic [1:0]                      o_status,
    output logic [6:0]                      o_entry_count
);

    import bdeq_pkg::*;

    logic [1:0]        r_kind;
    logic [WORD_W-1:0] r_value;
    logic [PTR_W-1:0]  r_bottom;
    logic [CNT_W-1:0]  r_count;
    logic [LIMIT_W-1:0] r_limit;
    logic [1:0]        r_status;
    logic              r_pop_ok;

    logic [PTR_W-1:0]  n_bottom;
    logic [CNT_W-1:0]  n_count;
    logic [1:0]        n_status;
    logic              n_pop_ok;

    logic              mem_we;
    logic [PTR_W-1:0]  mem_addr;
    logic [WORD_W-1:0] mem_rdata;

    logic [ADD_W-1:0]  top_sum;
    logic [PTR_W-1:0]  top_push_addr;
    logic [PTR_W-1:0]  top_pop_addr;
    logic [PTR_W-1:0]  bottom_dec;
    logic [PTR_W-1:0]  bottom_inc;
    logic              is_full;
    logic              is_empty;

    function automatic logic [PTR_W-1:0] ring_wrap(input logic [ADD_W-1:0] s);
        logic [ADD_W-1:0] r;
        r = s;
        if (s >= ADD_W'(CAPACITY)) begin
            r = s - ADD_W'(CAPACITY);
        end
        return r[PTR_W-1:0];
    endfunction

    always_comb begin
        top_sum       = ADD_W'(r_bottom) + ADD_W'(r_count);
        top_push_addr = ring_wrap(top_sum);
        top_pop_addr  = ring_wrap(top_sum - ADD_W'(1));
        bottom_dec    = (r_bottom == '0) ? PTR_W'(CAPACITY - 1) : r_bottom - PTR_W'(1);
        bottom_inc    = ring_wrap(ADD_W'(r_bottom) + ADD_W'(1));
        is_full       = (CMP_W'(r_count) >= CMP_W'(r_limit)) ||
                        (r_count >= CNT_W'(CAPACITY));
        is_empty      = (r_count == '0);

        n_bottom = r_bottom;
        n_count  = r_count;
        n_status = ST_OK;
        n_pop_ok = 1'b0;
        mem_we   = 1'b0;
        mem_addr = r_bottom;

        case (t_kind'(r_kind))
            KIND_PUSH_TOP: begin
                mem_addr = top_push_addr;
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we  = i_cmd.exec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_PUSH_BOTTOM: begin
                mem_addr = bottom_dec;
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we   = i_cmd.exec;
                    n_bottom = bottom_dec;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            KIND_POP_TOP: begin
                mem_addr = top_pop_addr;
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            KIND_POP_BOTTOM: begin
                mem_addr = r_bottom;
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    n_bottom = bottom_inc;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bottom <= '0;
            r_count  <= '0;
            r_limit  <= LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_bottom <= n_bottom;
                r_count  <= n_count;
            end
        end
    end

    bdeq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (r_value),
        .o_rdata (mem_rdata)
    );

    assign o_pop_value   = r_pop_ok ? $signed(mem_rdata) : '0;
    assign o_status      = r_status;
    assign o_entry_count = 7'(r_count);

endmodule

FILE: hdl/bounded_two_ended_stack_top.sv
// after the start transfer the controller passes through its execute state; the strobe
// and the result are registered as it leaves that state; a new request is taken only in
// the idle state, after the execute and result states around the single port ram access
// reset: synchronous active low, empties the store and sets the limit to 64
// results cannot be stalled by the receiver
module bounded_two_ended_stack_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_kind,
    input  logic signed [31:0]            i_push_value,
    output logic                          o_strobe,
    output logic signed [31:0]            o_pop_value,
    output logic [1:0]                    o_status,
    output logic [6:0]                    o_entry_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bdeq_pkg::LIMIT_W-1:0]  i_cfg_data
);

    import bdeq_pkg::*;

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    bdeq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    bdeq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (i_kind),
        .i_push_value  (i_push_value),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_pop_value   (o_pop_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bdeq_pkg::*;

    typedef struct {
        logic [WORD_W-1:0] word;
        t_status           status;
        logic [6:0]        count;
    } t_answer;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                i_kind;
    logic signed [31:0]        i_push_value;
    logic                      o_strobe;
    logic signed [31:0]        o_pop_value;
    logic [1:0]                o_status;
    logic [6:0]                o_entry_count;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [LIMIT_W-1:0]        i_cfg_data;

    // shadow copy of the ring buffer
    logic [WORD_W-1:0]         ring_mem [CAPACITY];
    logic [PTR_W-1:0]          ring_bottom;
    int                        ring_count;
    logic [LIMIT_W-1:0]        limit_reg;

    t_answer                   answer_q [$];
    int                        fail_count;
    int                        sender_idle_pct;

    bounded_two_ended_stack_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_push_value  (i_push_value),
        .o_strobe      (o_strobe),
        .o_pop_value   (o_pop_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_answer deque_apply(input t_kind kind, input logic [WORD_W-1:0] word);
        t_answer          ans;
        logic [PTR_W-1:0] slot;
        ans.word   = '0;
        ans.status = ST_OK;
        if (kind == KIND_PUSH_TOP || kind == KIND_PUSH_BOTTOM) begin
            if (ring_count >= int'(limit_reg) || ring_count >= CAPACITY) begin
                ans.status = ST_FULL;
            end else if (kind == KIND_PUSH_TOP) begin
                slot = ring_bottom + PTR_W'(ring_count);
                ring_mem[slot] = word;
                ring_count++;
            end else begin
                ring_bottom = ring_bottom - 1'b1;
                ring_mem[ring_bottom] = word;
                ring_count++;
            end
        end else begin
            if (ring_count == 0) begin
                ans.status = ST_EMPTY;
            end else if (kind == KIND_POP_TOP) begin
                ring_count--;
                slot = ring_bottom + PTR_W'(ring_count);
                ans.word = ring_mem[slot];
            end else begin
                ans.word = ring_mem[ring_bottom];
                ring_bottom = ring_bottom + 1'b1;
                ring_count--;
            end
        end
        ans.count = 7'(ring_count);
        return ans;
    endfunction

    task automatic note_fail(input string what);
        fail_count++;
        if (fail_count <= 10) $display("%s", what);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_strobe) begin
            if (answer_q.size() == 0) begin
                note_fail($sformatf("unexpected result: value %0d status %0d count %0d",
                          o_pop_value, o_status, o_entry_count));
            end else begin
                exp_ans = answer_q[0];
                answer_q.delete(0);
                if (o_pop_value !== exp_ans.word || o_status !== exp_ans.status ||
                    o_entry_count !== exp_ans.count) begin
                    note_fail($sformatf({"mismatch: expected value %0d status %0d count %0d,",
                              " got value %0d status %0d count %0d"},
                              $signed(exp_ans.word), exp_ans.status, exp_ans.count,
                              o_pop_value, o_status, o_entry_count));
                end
            end
        end
    end

    task automatic send_req(input t_kind kind, input logic [WORD_W-1:0] word);
        int gap;
        start        <= 1'b1;
        i_kind       <= kind;
        i_push_value <= word;
        do @(posedge i_clk); while (busy);
        answer_q.insert(answer_q.size(), deque_apply(kind, word));
        if ($urandom_range(99) < sender_idle_pct) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    task automatic test_edge_values();
        send_req(KIND_POP_TOP, $urandom);
        send_req(KIND_POP_BOTTOM, $urandom);
        send_req(KIND_PUSH_TOP, 32'h7fff_ffff);
        send_req(KIND_PUSH_BOTTOM, 32'h8000_0000);
        send_req(KIND_PUSH_TOP, 32'h0000_0000);
        send_req(KIND_PUSH_BOTTOM, 32'hffff_ffff);
        send_req(KIND_POP_TOP, $urandom);
        send_req(KIND_POP_BOTTOM, $urandom);
        send_req(KIND_POP_TOP, $urandom);
        send_req(KIND_POP_BOTTOM, $urandom);
        send_req(KIND_POP_BOTTOM, $urandom);
    endtask

    task automatic test_limit_changes();
        send_req(KIND_PUSH_TOP, 32'h0000_0001);
        send_req(KIND_PUSH_BOTTOM, 32'h5555_5555);
        send_req(KIND_PUSH_TOP, 32'haaaa_aaaa);
        // limit below the current count
        write_limit(7'd1);
        send_req(KIND_PUSH_TOP, $urandom);
        send_req(KIND_POP_TOP, $urandom);
        send_req(KIND_PUSH_BOTTOM, $urandom);
        send_req(KIND_POP_BOTTOM, $urandom);
        send_req(KIND_PUSH_TOP, $urandom);
        send_req(KIND_POP_BOTTOM, $urandom);
        write_limit(7'd0);
        send_req(KIND_PUSH_TOP, $urandom);
        send_req(KIND_PUSH_BOTTOM, $urandom);
        send_req(KIND_POP_TOP, $urandom);
        send_req(KIND_POP_TOP, $urandom);
    endtask

    task automatic test_capacity(input logic [LIMIT_W-1:0] value);
        write_limit(value);
        repeat (CAPACITY + 2) begin
            send_req($urandom_range(1) ? KIND_PUSH_TOP : KIND_PUSH_BOTTOM, $urandom);
        end
        repeat (CAPACITY + 2) begin
            send_req($urandom_range(1) ? KIND_POP_TOP : KIND_POP_BOTTOM, $urandom);
        end
    endtask

    task automatic test_random(input logic [LIMIT_W-1:0] value, input int count);
        int push_pct;
        write_limit(value);
        for (int n = 0; n < count; n++) begin
            push_pct = (n < count / 2) ? 70 : 30;
            if (n == count / 2) wait_drained();
            if ($urandom_range(99) < push_pct) begin
                send_req($urandom_range(1) ? KIND_PUSH_TOP : KIND_PUSH_BOTTOM, $urandom);
            end else begin
                send_req($urandom_range(1) ? KIND_POP_TOP : KIND_POP_BOTTOM, $urandom);
            end
        end
    endtask

    initial begin
        logic [LIMIT_W-1:0] phase_limit [9];
        phase_limit = '{7'd64, 7'd127, 7'd100, 7'd63, 7'd5, 7'd2, 7'd1, 7'd0, 7'd40};
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_kind          <= KIND_PUSH_TOP;
        i_push_value    <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        fail_count      = 0;
        sender_idle_pct = 38;
        for (int i = 0; i < CAPACITY; i++) ring_mem[i] = '0;
        ring_bottom = '0;
        ring_count  = 0;
        limit_reg   = LIMIT_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_values();
        test_limit_changes();
        test_capacity(7'd127);
        test_capacity(7'd64);
        for (int p = 0; p < 9; p++) begin
            sender_idle_pct = (p < 3) ? 38 : (p < 6) ? 85 : 0;
            test_random(phase_limit[p], 170);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && answer_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/bdeq_pkg.sv
hdl/bdeq_ram.sv
hdl/bdeq_ctrl.sv
hdl/bdeq_dp.sv
hdl/bounded_two_ended_stack_top.sv
tb/testbench.sv
